// File: src/gre_pkg.sv
// Shared constants, types and the exponential table function for the
// Gaussian RBF evaluator. No dependencies.
package gre_pkg;

  localparam int GRE_MAX_CENTERS = 64;
  localparam int GRE_EXP_DEPTH   = 1024;

  localparam int OPCODE_W = 1;
  localparam int SLOT_W   = 6;
  localparam int COORD_W  = 16;
  localparam int WEIGHT_W = 32;
  localparam int VALUE_W  = 48;
  localparam int CFG_W    = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  x;
  } center_t;

  localparam logic [63:0] Q32_ONE         = 64'h1_0000_0000;
  localparam logic [63:0] EXP_NEG_ONE_Q32 = 64'd1580030169;
  localparam int          TAYLOR_TERMS    = 20;
  localparam int          MAX_WHOLE       = 16;

  // Table entry exp(-t) as unsigned Q1.16, where t is given in Q32.32.
  // The fraction goes through a truncated Taylor series, each whole unit
  // multiplies by exp(-1), and the Q0.32 value is rounded half up.
  function automatic logic [16:0] exp_rom_entry(logic [63:0] tq);
    logic [63:0]        whole;
    logic [63:0]        frac;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        val;
    whole = tq >> 32;
    frac  = {32'd0, tq[31:0]};
    term  = Q32_ONE;
    sum   = $signed(Q32_ONE);
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * frac) >> 32) / 64'(k);
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    val = (sum < 0) ? 64'd0 : $unsigned(sum);
    if (val > Q32_ONE) begin
      val = Q32_ONE;
    end
    for (int k = 0; k < MAX_WHOLE; k++) begin
      if (64'(k) < whole) begin
        val = (val * EXP_NEG_ONE_Q32) >> 32;
      end
    end
    return 17'((val + 64'd32768) >> 16);
  endfunction

endpackage

// File: src/gre_if.sv
// Handshake channels of the Gaussian RBF evaluator: input items and results.
// Depends on gre_pkg for the field widths.
interface gre_in_if import gre_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [SLOT_W-1:0]          slot;
  logic signed [COORD_W-1:0]  x_coord;
  logic signed [COORD_W-1:0]  y_coord;
  logic signed [WEIGHT_W-1:0] weight_in;

  modport source (output valid, opcode, slot, x_coord, y_coord, weight_in, input ready);
  modport sink   (input valid, opcode, slot, x_coord, y_coord, weight_in, output ready);
endinterface

interface gre_out_if import gre_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] surface_value;
  logic                      saturated;

  modport source (output valid, surface_value, saturated, input ready);
  modport sink   (input valid, surface_value, saturated, output ready);
endinterface

// File: src/gre_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/gaussian_rbf_evaluate.sv
// Gaussian RBF surface evaluator top level; uses gre_pkg, gre_if and gre_ram.
// A query over N > 0 centers streams one center per cycle through the center
// pipeline. No new item is taken until the result of a query has been loaded
// into the output register. Synchronous active-low reset clears control state
// and sets centers_in_use to 1; the store is not cleared.
module gaussian_rbf_evaluate import gre_pkg::*; #(
  parameter int MAX_CENTERS     = GRE_MAX_CENTERS,
  parameter int EXP_TABLE_DEPTH = GRE_EXP_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  gre_in_if.sink           in_chan,
  gre_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // Address of a center slot, and a counter wide enough to hold the count itself.
  localparam int AW   = $clog2(MAX_CENTERS);
  localparam int CW   = $clog2(MAX_CENTERS + 1);
  localparam int RA_W = $clog2(EXP_TABLE_DEPTH);
  // The table spans a squared distance below 16.0 in Q.16, which is 2^20.
  localparam int D_SHIFT = 20;
  localparam int D_W     = 33;
  localparam int PA_W    = D_SHIFT + $clog2(EXP_TABLE_DEPTH + 1);
  localparam int SQ_W    = 32;
  localparam int E_W     = 17;
  localparam int PROD_W  = WEIGHT_W + E_W + 1;
  localparam int ACC_W   = PROD_W + AW + 1;
  localparam int FRAC_W  = 16;
  localparam int RW      = ACC_W - FRAC_W;
  localparam int ROUND_HALF = 32768;
  localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;

  // The sequencer walks the centers, waits for the pipeline to drain, rounds
  // the sum and then saturates it into the output register.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WALK  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_SAT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] centers_in_use_r;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_sel;

  logic signed [COORD_W-1:0] qx_r;
  logic signed [COORD_W-1:0] qy_r;

  logic in_xfer;
  logic is_query;
  logic slot_ok;
  logic issue;
  logic pipe_busy;

  // Valid bits of the center pipeline, one per stage.
  logic v_rd_r, v_sq_r, v_d_r, v_ra_r, v_rom_r, v_prod_r;

  center_t ram_wdata;
  center_t ram_rdata;

  logic signed [COORD_W:0]     dx, dy;
  logic signed [2*COORD_W+1:0] sq_x_full, sq_y_full;
  logic [SQ_W-1:0]             sq_x_r, sq_y_r;
  logic [D_W-1:0]              d_r;
  logic [PA_W-1:0]             addr_prod;
  logic [RA_W-1:0]             rom_addr_r;
  logic                        inr_ra_r, inr_rom_r;
  logic [E_W-1:0]              exp_rom [EXP_TABLE_DEPTH];
  logic [E_W-1:0]              rom_q_r;
  logic [E_W-1:0]              e_sel;

  logic signed [WEIGHT_W-1:0] w_sq_r, w_d_r, w_ra_r, w_rom_r;
  logic signed [PROD_W-1:0]   prod_full;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [RW-1:0]       rnd_r;
  logic signed [63:0]         rnd_ext;

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic                      out_sat_r;
  logic                      out_load;

  // The exponential table is built at elaboration from the address grid.
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp_rom
    localparam logic [63:0] TQ = ((64'(g) * 64'd16) << 32) / 64'(EXP_TABLE_DEPTH);
    assign exp_rom[g] = exp_rom_entry(TQ);
  end

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign is_query      = (in_chan.opcode == OP_QUERY);
  // Loads aimed past the end of the store are dropped.
  assign slot_ok       = 32'(in_chan.slot) < 32'(MAX_CENTERS);

  // A count above the store depth is clamped to it.
  assign count_sel = (32'(centers_in_use_r) > 32'(MAX_CENTERS)) ? CW'(MAX_CENTERS)
                                                                : CW'(centers_in_use_r);

  assign issue     = (state_r == ST_WALK);
  assign pipe_busy = v_rd_r || v_sq_r || v_d_r || v_ra_r || v_rom_r || v_prod_r;
  assign out_load  = (state_r == ST_SAT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && is_query) begin
          idx_nxt   = '0;
          state_nxt = (count_sel == '0) ? ST_DRAIN : ST_WALK;
        end
      end
      ST_WALK: begin
        idx_nxt = idx_r + CW'(1);
        if (idx_nxt == count_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      centers_in_use_r <= CFG_W'(1);
      idx_r            <= '0;
      v_rd_r           <= 1'b0;
      v_sq_r           <= 1'b0;
      v_d_r            <= 1'b0;
      v_ra_r           <= 1'b0;
      v_rom_r          <= 1'b0;
      v_prod_r         <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      v_rd_r   <= issue;
      v_sq_r   <= v_rd_r;
      v_d_r    <= v_sq_r;
      v_ra_r   <= v_d_r;
      v_rom_r  <= v_ra_r;
      v_prod_r <= v_rom_r;
      if (cfg_we) begin
        centers_in_use_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Center store: x, y and weight packed into one word per slot.
  assign ram_wdata = '{weight: in_chan.weight_in, y: in_chan.y_coord, x: in_chan.x_coord};

  gre_ram #(
    .WIDTH ($bits(center_t)),
    .DEPTH (MAX_CENTERS)
  ) u_center_ram (
    .clk   (clk),
    .we    (in_xfer && !is_query && slot_ok),
    .waddr (AW'(in_chan.slot)),
    .wdata (ram_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Distance stage: offsets are exact in Q9.8, their squares are below 2^32.
  assign dx        = {qx_r[COORD_W-1], qx_r} - {ram_rdata.x[COORD_W-1], ram_rdata.x};
  assign dy        = {qy_r[COORD_W-1], qy_r} - {ram_rdata.y[COORD_W-1], ram_rdata.y};
  assign sq_x_full = dx * dx;
  assign sq_y_full = dy * dy;

  // Table address floor(d * depth / 16) is a constant multiply and a shift.
  assign addr_prod = PA_W'(d_r[D_SHIFT-1:0]) * PA_W'(EXP_TABLE_DEPTH);

  // Past the end of the table the kernel is zero.
  assign e_sel     = inr_rom_r ? rom_q_r : '0;
  assign prod_full = w_rom_r * $signed({1'b0, e_sel});

  // Round half up to Q.16; an arithmetic shift gives the floor for both signs.
  assign acc_rnd = acc_r + ACC_W'(ROUND_HALF);
  assign rnd_ext = 64'(rnd_r);

  always_ff @(posedge clk) begin
    if (in_xfer && is_query) begin
      qx_r    <= in_chan.x_coord;
      qy_r    <= in_chan.y_coord;
      count_r <= count_sel;
    end
    sq_x_r     <= sq_x_full[SQ_W-1:0];
    sq_y_r     <= sq_y_full[SQ_W-1:0];
    w_sq_r     <= ram_rdata.weight;
    d_r        <= {1'b0, sq_x_r} + {1'b0, sq_y_r};
    w_d_r      <= w_sq_r;
    rom_addr_r <= RA_W'(addr_prod >> D_SHIFT);
    inr_ra_r   <= (d_r[D_W-1:D_SHIFT] == '0);
    w_ra_r     <= w_d_r;
    rom_q_r    <= exp_rom[rom_addr_r];
    inr_rom_r  <= inr_ra_r;
    w_rom_r    <= w_ra_r;
    prod_r     <= prod_full;
    if (in_xfer && is_query) begin
      acc_r <= '0;
    end else if (v_prod_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (state_r == ST_ROUND) begin
      rnd_r <= acc_rnd[ACC_W-1:FRAC_W];
    end
    if (out_load) begin
      priority if (rnd_ext > OUT_MAX) begin
        out_value_r <= VALUE_W'(OUT_MAX);
        out_sat_r   <= 1'b1;
      end else if (rnd_ext < OUT_MIN) begin
        out_value_r <= VALUE_W'(OUT_MIN);
        out_sat_r   <= 1'b1;
      end else begin
        out_value_r <= VALUE_W'(rnd_ext);
        out_sat_r   <= 1'b0;
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.surface_value = out_value_r;
  assign out_chan.saturated     = out_sat_r;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the Gaussian RBF surface evaluator (gaussian_rbf_evaluate).
// Depends on gre_pkg, the gre_in_if/gre_out_if interfaces and the RTL top level.
// A scoreboard class predicts each query height and checks every result transfer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gre_pkg::*;

  // Run limits. The slowest legal query walks every stored center in the block. Add
  // the longest sender gap and the longest receiver stall on top of that, and the
  // watchdog still allows several times the total that about 1350 such items take.
  localparam int WATCHDOG_CYCLES = 800_000;
  localparam int LOAD_SETTLE     = 16;
  localparam int END_SETTLE      = 80;
  localparam int PHASES          = 12;
  localparam int PHASE_ITEMS     = 100;

  localparam longint unsigned EXP_MINUS_ONE_Q32 = 64'd1580030169;
  localparam longint          DIST_LIMIT        = 64'sd16 <<< 16;
  localparam longint          VALUE_MAX         = (64'sd1 <<< (VALUE_W - 1)) - 1;
  localparam longint          VALUE_MIN         = -VALUE_MAX - 1;

  // Center counts for each random phase. The plan covers the extremes, zero,
  // and counts above the store depth.
  localparam logic [CFG_W-1:0] PHASE_PLAN [PHASES] =
    '{7'd64, 7'd127, 7'd3, 7'd65, 7'd1, 7'd0, 7'd16, 7'd2, 7'd64, 7'd9, 7'd33, 7'd5};

  typedef struct {
    opcode_t                    op;
    logic [SLOT_W-1:0]          slot;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [WEIGHT_W-1:0] w;
  } rbf_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      sat;
  } height_t;

  // Scoreboard that keeps its own copy of the center store, the center count
  // and the exp(-d) table. It queues the predicted height of each query.
  class rbf_height_board;
    logic signed [COORD_W-1:0]  center_x [GRE_MAX_CENTERS];
    logic signed [COORD_W-1:0]  center_y [GRE_MAX_CENTERS];
    logic signed [WEIGHT_W-1:0] center_w [GRE_MAX_CENTERS];
    logic [16:0]                kernel_rom [GRE_EXP_DEPTH];
    logic [CFG_W-1:0]           centers_in_use;
    height_t                    pending_heights [$];
    int                         errors;

    function new();
      longint unsigned tq;
      longint unsigned frac;
      longint unsigned term;
      longint unsigned val;
      longint          series;
      for (int a = 0; a < GRE_EXP_DEPTH; a++) begin
        tq     = ((64'(a) * 64'd16) << 32) / 64'(GRE_EXP_DEPTH);
        frac   = tq & 64'hFFFF_FFFF;
        term   = 64'd1 << 32;
        series = longint'(term);
        for (int k = 1; k <= 20; k++) begin
          term = ((term * frac) >> 32) / 64'(k);
          if (k % 2 == 1) begin
            series = series - longint'(term);
          end else begin
            series = series + longint'(term);
          end
        end
        val = (series < 0) ? 64'd0 : $unsigned(series);
        if (val > (64'd1 << 32)) begin
          val = 64'd1 << 32;
        end
        for (longint unsigned u = 0; u < (tq >> 32); u++) begin
          val = (val * EXP_MINUS_ONE_Q32) >> 32;
        end
        kernel_rom[a] = 17'((val + 64'd32768) >> 16);
      end
      centers_in_use = 1;
      errors = 0;
    endfunction

    function void set_centers(logic [CFG_W-1:0] count);
      centers_in_use = count;
    endfunction

    function void note_item(rbf_item_t it);
      longint  acc;
      longint  dx;
      longint  dy;
      longint  sq_dist;
      longint  kern;
      longint  rounded;
      int      count;
      height_t h;
      if (it.op == OP_LOAD) begin
        if (it.slot < GRE_MAX_CENTERS) begin
          center_x[it.slot] = it.x;
          center_y[it.slot] = it.y;
          center_w[it.slot] = it.w;
        end
        return;
      end
      count = (centers_in_use > GRE_MAX_CENTERS) ? GRE_MAX_CENTERS : int'(centers_in_use);
      acc = 0;
      for (int i = 0; i < count; i++) begin
        dx      = longint'(it.x) - longint'(center_x[i]);
        dy      = longint'(it.y) - longint'(center_y[i]);
        sq_dist = dx * dx + dy * dy;
        kern    = (sq_dist < DIST_LIMIT) ?
                  longint'(kernel_rom[(sq_dist * GRE_EXP_DEPTH) >>> 20]) : 64'sd0;
        acc     = acc + longint'(center_w[i]) * kern;
      end
      // Rounding half up to Q.16 is a floor after adding one half.
      rounded = (acc + 64'sd32768) >>> 16;
      h.sat = 1'b0;
      if (rounded > VALUE_MAX) begin
        rounded = VALUE_MAX;
        h.sat = 1'b1;
      end else if (rounded < VALUE_MIN) begin
        rounded = VALUE_MIN;
        h.sat = 1'b1;
      end
      h.value = rounded[VALUE_W-1:0];
      pending_heights.insert(pending_heights.size(), h);
    endfunction

    function void check_height(logic signed [VALUE_W-1:0] value, logic sat);
      height_t want;
      if (pending_heights.size() == 0) begin
        $error("result transfer with no query waiting: surface_value=%0d", value);
        errors++;
        return;
      end
      want = pending_heights.pop_front();
      if (value !== want.value) begin
        $error("surface_value mismatch: expected %0d, actual %0d",
               $signed(want.value), value);
        errors++;
      end
      if (sat !== want.sat) begin
        $error("saturated mismatch: expected %0d, actual %0d", want.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  bit               idle_on;

  gre_in_if  in_if ();
  gre_out_if out_if ();

  rbf_height_board sb = new();

  gaussian_rbf_evaluate u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side. Ready drops in random bursts while idling is enabled. It changes
  // only at the falling edge, so at the rising edge it is stable.
  initial begin : result_ready
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is checked against the oldest predicted height.
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check_height(out_if.surface_value, out_if.saturated);
    end
  end

  function automatic logic signed [COORD_W-1:0] clamp_coord(int v);
    if (v > 32767) begin
      return 16'sd32767;
    end
    if (v < -32768) begin
      return -16'sd32768;
    end
    return COORD_W'(v);
  endfunction

  // Weights lean on the extremes and on small values, where rounding shows.
  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: begin
        return 32'sh7FFF_FFFF;
      end
      1: begin
        return 32'sh8000_0000;
      end
      2, 3: begin
        return WEIGHT_W'(int'($urandom_range(0, 131071)) - 65536);
      end
      default: begin
        return WEIGHT_W'($urandom);
      end
    endcase
  endfunction

  // Presents one item and returns at the rising edge where it transfers. Valid
  // stays high afterward, so back-to-back items need no extra assignment.
  task automatic send(opcode_t op, int slot, int x, int y, logic signed [WEIGHT_W-1:0] w);
    rbf_item_t it;
    int        gap;
    it.op   = op;
    it.slot = SLOT_W'(slot);
    it.x    = clamp_coord(x);
    it.y    = clamp_coord(y);
    it.w    = w;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_if.valid     <= 1'b1;
    in_if.opcode    <= it.op;
    in_if.slot      <= it.slot;
    in_if.x_coord   <= it.x;
    in_if.y_coord   <= it.y;
    in_if.weight_in <= it.w;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_item(it);
  endtask

  // Stops the sender and waits until every predicted height has been checked.
  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending_heights.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The count is written only while the block is idle. A trailing load can
  // still be in progress after the last result, so a short settle follows the drain.
  task automatic write_centers_in_use(logic [CFG_W-1:0] count);
    drain_results();
    repeat (LOAD_SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_centers(count);
  endtask

  initial begin : stimulus
    int               base_x;
    int               base_y;
    int               active;
    int               pick;
    int               aim;
    logic [CFG_W-1:0] new_count;

    in_if.valid     = 1'b0;
    in_if.opcode    = OP_LOAD;
    in_if.slot      = '0;
    in_if.x_coord   = '0;
    in_if.y_coord   = '0;
    in_if.weight_in = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    idle_on         = 1'b1;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The count is 1 after reset, so only slot 0 has to be loaded.
    // Unit weight at the origin: a distance of zero, one unit, just inside the
    // table range, and exactly at its edge.
    send(OP_LOAD, 0, 0, 0, 32'sd65536);
    send(OP_QUERY, 0, 0, 0, 32'sd0);
    send(OP_QUERY, 0, 256, 0, 32'sd0);
    send(OP_QUERY, 0, 1023, 0, 32'sd0);
    send(OP_QUERY, 0, 1024, 0, 32'sd0);
    // Largest weight at the top corner, queried there and from the far corner.
    send(OP_LOAD, 0, 32767, 32767, 32'sh7FFF_FFFF);
    send(OP_QUERY, 0, 32767, 32767, 32'sd0);
    send(OP_QUERY, 0, -32768, -32768, 32'sd0);
    // Most negative weight at the bottom corner.
    send(OP_LOAD, 0, -32768, -32768, 32'sh8000_0000);
    send(OP_QUERY, 0, -32768, -32768, 32'sd0);
    send(OP_QUERY, 0, 32767, 32767, 32'sd0);
    // A tiny negative weight. This checks the rounding of negative sums.
    send(OP_LOAD, 0, 0, 0, -32'sd1);
    send(OP_QUERY, 0, 0, 0, 32'sd0);
    send(OP_QUERY, 0, 128, 0, 32'sd0);
    // A small neighborhood of centers for a multi-term sum. The last slot is
    // loaded as well.
    send(OP_LOAD, 1, 256, 256, 32'sd196608);
    send(OP_LOAD, 2, -256, 0, -32'sd131072);
    send(OP_LOAD, 3, 0, -128, 32'sd32768);
    send(OP_LOAD, 63, 100, -100, 32'sd12345);
    write_centers_in_use(7'd4);
    send(OP_QUERY, 0, 0, 0, 32'sd0);
    send(OP_QUERY, 0, 64, 64, 32'sd0);
    // A count of zero sums nothing.
    write_centers_in_use(7'd0);
    send(OP_QUERY, 0, 0, 0, 32'sd0);
    write_centers_in_use(7'd1);

    // Fill every slot around one cluster. After that, any count can be used
    // without reading a slot that was never written.
    base_x = int'($urandom_range(0, 65535)) - 32768;
    base_y = int'($urandom_range(0, 65535)) - 32768;
    for (int s = 0; s < GRE_MAX_CENTERS; s++) begin
      send(OP_LOAD, s, base_x + int'($urandom_range(0, 1536)) - 768,
           base_y + int'($urandom_range(0, 1536)) - 768, pick_weight());
    end

    // Random phases. Each phase sets a new count between drains. Most items
    // are queries aimed at or near a stored center, so the kernel is mostly nonzero.
    // The rest are loads and noise queries anywhere in the plane.
    for (int p = 0; p < PHASES; p++) begin
      new_count = (p == 7) ? CFG_W'($urandom_range(1, GRE_MAX_CENTERS)) : PHASE_PLAN[p];
      write_centers_in_use(new_count);
      idle_on = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      base_x  = int'($urandom_range(0, 65535)) - 32768;
      base_y  = int'($urandom_range(0, 65535)) - 32768;
      active  = (new_count == 0) ? 1 :
                ((new_count > GRE_MAX_CENTERS) ? GRE_MAX_CENTERS : int'(new_count));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        aim  = $urandom_range(0, active - 1);
        if (pick < 25) begin
          send(OP_LOAD, $urandom_range(0, GRE_MAX_CENTERS - 1),
               base_x + int'($urandom_range(0, 1536)) - 768,
               base_y + int'($urandom_range(0, 1536)) - 768, pick_weight());
        end else if (pick < 30) begin
          send(OP_LOAD, $urandom_range(0, GRE_MAX_CENTERS - 1),
               int'($urandom_range(0, 65535)) - 32768,
               int'($urandom_range(0, 65535)) - 32768, WEIGHT_W'($urandom));
        end else if (pick < 38) begin
          send(OP_QUERY, $urandom_range(0, GRE_MAX_CENTERS - 1),
               int'(sb.center_x[aim]), int'(sb.center_y[aim]), WEIGHT_W'($urandom));
        end else if (pick < 88) begin
          send(OP_QUERY, $urandom_range(0, GRE_MAX_CENTERS - 1),
               int'(sb.center_x[aim]) + int'($urandom_range(0, 2200)) - 1100,
               int'(sb.center_y[aim]) + int'($urandom_range(0, 2200)) - 1100,
               WEIGHT_W'($urandom));
        end else begin
          send(OP_QUERY, $urandom_range(0, GRE_MAX_CENTERS - 1),
               int'($urandom_range(0, 65535)) - 32768,
               int'($urandom_range(0, 65535)) - 32768, WEIGHT_W'($urandom));
        end
        // Now and then the sender holds off until the block has drained.
        if ($urandom_range(0, 199) == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
